// File: rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 digest core.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned NUM_HASH = 5;
    localparam int unsigned NUM_SCHED = 16;
    localparam int unsigned ROUNDS   = 80;
    localparam int unsigned CNT_W    = 61;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word H_INIT [NUM_HASH] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam t_word K_0 = 32'h5a827999;
    localparam t_word K_1 = 32'h6ed9eba1;
    localparam t_word K_2 = 32'h8f1bbcdc;
    localparam t_word K_3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [6:0] LAST_RND  = 7'd79;
    localparam logic [2:0] LAST_WORD = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

endpackage

// File: rtl/sha1_message_digest_core.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// Streaming SHA-1: one byte per transfer in, five digest words out.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with i_data_byte, i_byte_present and
// i_end_of_message. A transfer with i_byte_present appends the byte; a
// transfer with i_end_of_message (alone or with a byte) closes the message.
// Output channel: o_out_valid / i_out_stall with five transfers per message,
// word 0 (H0) first, o_last_word set on word 4.
// A byte that does not fill a block is taken and the core stays ready for the
// next. The 64th byte of a block starts the compression: the 80 rounds run
// one at a time through the single round adder, then the chaining add, and
// no byte is taken until both are done. Closing a message feeds the padding
// and the length one byte per cycle through the same byte path (64 - n bytes
// with n bytes in the open block, 64 more when n >= 56), compressing after
// each padded block. The digest words are shown once the chaining add of
// the last padded block is done; with no stall the five words follow on
// consecutive cycles.
// o_in_stall is high whenever the sequencer is busy: through a compression
// and its chaining add, and from the closing transfer until the last digest
// word has been transferred. While i_out_stall is high the current digest
// word holds. Reset (synchronous, active low) loads the SHA-1 initial values
// and clears the byte count and the sequencer.
// ----------------------------------------------------------------------------
module sha1_message_digest_core
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_number,
    output logic        o_last_word
);

    t_state           r_state, n_state;
    t_word            r_hash [NUM_HASH];
    t_word            n_hash [NUM_HASH];
    t_word            r_a, r_b, r_c, r_d, r_e;
    t_word            n_a, n_b, n_c, n_d, n_e;
    t_word            r_win [NUM_SCHED];
    t_word            n_win [NUM_SCHED];
    logic [23:0]      r_acc, n_acc;
    logic [5:0]       r_pos, n_pos;
    logic [CNT_W-1:0] r_count, n_count;
    logic [63:0]      r_len, n_len;
    logic [6:0]       r_rnd, n_rnd;
    logic [2:0]       r_wsel, n_wsel;
    logic             r_finish, n_finish;
    logic             r_pad_first, n_pad_first;
    logic             r_len_ok, n_len_ok;
    logic             r_final, n_final;

    logic             in_xfer;
    logic             push;
    logic [7:0]       push_byte;
    t_word            f_val, k_val, sched_new, round_sum;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid   = (r_state == ST_OUT);
    assign o_digest_word = r_hash[r_wsel];
    assign o_word_number = r_wsel;
    assign o_last_word   = (r_wsel == LAST_WORD);

    // round function and schedule expansion (window holds W[t]..W[t+15])
    always_comb begin
        if (r_rnd < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = K_0;
        end else if (r_rnd < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_1;
        end else if (r_rnd < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K_2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_3;
        end
        sched_new = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        sched_new = {sched_new[30:0], sched_new[31]};
        round_sum = {r_a[26:0], r_a[31:27]} + f_val + r_e + r_win[0] + k_val;
    end

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e;
        n_win       = r_win;
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_count     = r_count;
        n_len       = r_len;
        n_rnd       = r_rnd;
        n_wsel      = r_wsel;
        n_finish    = r_finish;
        n_pad_first = r_pad_first;
        n_len_ok    = r_len_ok;
        n_final     = r_final;
        push        = 1'b0;
        push_byte   = 8'h00;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_byte_present) begin
                        push      = 1'b1;
                        push_byte = i_data_byte;
                        n_count   = r_count + 1'b1;
                    end
                    if (i_end_of_message) begin
                        n_finish    = 1'b1;
                        n_pad_first = 1'b1;
                        n_state     = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                push = 1'b1;
                if (r_pad_first) begin
                    push_byte   = PAD_BYTE;
                    n_pad_first = 1'b0;
                    n_len       = {r_count, 3'b000};
                    n_len_ok    = (r_pos < LEN_POS);
                end else if (r_len_ok && r_pos >= LEN_POS) begin
                    push_byte = r_len[63:56];
                    n_len     = {r_len[55:0], 8'h00};
                    if (r_pos == LAST_POS) begin
                        n_final = 1'b1;
                    end
                end
            end
            ST_ROUND: begin
                n_e = r_d;
                n_d = r_c;
                n_c = {r_b[1:0], r_b[31:2]};
                n_b = r_a;
                n_a = round_sum;
                for (int i = 0; i < NUM_SCHED - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[NUM_SCHED-1] = sched_new;
                n_rnd = r_rnd + 1'b1;
                if (r_rnd == LAST_RND) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_hash[0] = r_hash[0] + r_a;
                n_hash[1] = r_hash[1] + r_b;
                n_hash[2] = r_hash[2] + r_c;
                n_hash[3] = r_hash[3] + r_d;
                n_hash[4] = r_hash[4] + r_e;
                if (r_final) begin
                    n_state = ST_OUT;
                    n_wsel  = '0;
                end else if (r_finish) begin
                    // fresh block during padding: length fits at its tail
                    n_state  = ST_PAD;
                    n_len_ok = 1'b1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_wsel = r_wsel + 1'b1;
                    if (r_wsel == LAST_WORD) begin
                        n_hash   = H_INIT;
                        n_count  = '0;
                        n_finish = 1'b0;
                        n_final  = 1'b0;
                        n_len_ok = 1'b0;
                        n_wsel   = '0;
                        n_state  = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // shared byte path: pack big-endian, shift a full word into the window
        if (push) begin
            n_acc = {r_acc[15:0], push_byte};
            if (r_pos[1:0] == 2'd3) begin
                for (int i = 0; i < NUM_SCHED - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[NUM_SCHED-1] = {r_acc, push_byte};
            end
            n_pos = r_pos + 1'b1;
            if (r_pos == LAST_POS) begin
                n_state = ST_ROUND;
                n_rnd   = '0;
                n_a     = r_hash[0];
                n_b     = r_hash[1];
                n_c     = r_hash[2];
                n_d     = r_hash[3];
                n_e     = r_hash[4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hash      <= H_INIT;
            r_pos       <= '0;
            r_count     <= '0;
            r_rnd       <= '0;
            r_wsel      <= '0;
            r_finish    <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_final     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_rnd       <= n_rnd;
            r_wsel      <= n_wsel;
            r_finish    <= n_finish;
            r_pad_first <= n_pad_first;
            r_len_ok    <= n_len_ok;
            r_final     <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_e   <= n_e;
        r_win <= n_win;
        r_acc <= n_acc;
        r_len <= n_len;
    end

`ifndef ASSERT_OFF
    // digest only shown once the final block has been fully consumed
    a_out_block_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pos == '0) && r_final)
        else $error("digest presented with a partial block");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_rnd <= LAST_RND))
        else $error("round index out of range");

    a_full_block_compresses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_byte_present && r_pos == LAST_POS) |=> (r_state == ST_ROUND))
        else $error("full block did not start compression");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_word) |=> !o_out_valid && !o_in_stall)
        else $error("core not idle after last digest word");

    a_len_only_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD && r_final) |-> (r_pos == '0))
        else $error("length field ended away from block end");
`endif

endmodule
